[rtl/core/sfce_pkg.sv]
// Shared types and constants for the serial flow control engine.
`default_nettype none

package sfce_pkg;

   localparam int IN_DEPTH_DEF   = 32;
   localparam int HIGH_WATER_DEF = 24;
   localparam int OUT_DEPTH_DEF  = 64;

   localparam int CMD_W     = 4;
   localparam int BYTE_W    = 8;
   localparam int CNT_W     = 6;
   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] REG_XOFF_CHAR = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_RAW_MODE  = CSR_IDX_W'(1);

   typedef enum logic [CMD_W-1:0] {
      CMD_RX_BYTE  = 4'd0,
      CMD_CTS      = 4'd1,
      CMD_TX_EMPTY = 4'd2,
      CMD_QUEUE    = 4'd3,
      CMD_START    = 4'd4,
      CMD_READ     = 4'd5,
      CMD_HSTOP    = 4'd6,
      CMD_HSTART   = 4'd7,
      CMD_INHIBIT  = 4'd8,
      CMD_CANCEL   = 4'd9
   } cmd_type;

   typedef enum logic [3:0] {
      OP_RX,
      OP_CTS,
      OP_TXE,
      OP_QUEUE,
      OP_START,
      OP_READ,
      OP_HSTOP,
      OP_HSTART,
      OP_INHIBIT,
      OP_CANCEL,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [BYTE_W-1:0] data;
      logic              level;
   } item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_DRAIN
   } back_st_type;

endpackage

`default_nettype wire

[rtl/core/sfce_front.sv]
// Front end: request intake, command decode and two-entry request queue.
`default_nettype none

module sfce_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [sfce_pkg::CMD_W-1:0]   req_cmd,
   input  logic [sfce_pkg::BYTE_W-1:0]  req_data,
   input  logic                         req_level,
   output logic                         item_valid,
   output sfce_pkg::item_type           item,
   input  logic                         item_pop
);
   import sfce_pkg::*;

   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   item_type   q_ff [2];
   item_type   decoded;
   logic       push, pop;

   always_comb begin
      decoded.data  = req_data;
      decoded.level = req_level;
      unique case (cmd_type'(req_cmd))
         CMD_RX_BYTE:  decoded.op = OP_RX;
         CMD_CTS:      decoded.op = OP_CTS;
         CMD_TX_EMPTY: decoded.op = OP_TXE;
         CMD_QUEUE:    decoded.op = OP_QUEUE;
         CMD_START:    decoded.op = OP_START;
         CMD_READ:     decoded.op = OP_READ;
         CMD_HSTOP:    decoded.op = OP_HSTOP;
         CMD_HSTART:   decoded.op = OP_HSTART;
         CMD_INHIBIT:  decoded.op = OP_INHIBIT;
         CMD_CANCEL:   decoded.op = OP_CANCEL;
         default:      decoded.op = OP_NONE;
      endcase
   end

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign item_valid = (count_ff != 2'd0);
   assign pop        = item_pop && item_valid;
   assign item       = q_ff[rd_ptr_ff];

   always_comb begin
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

`default_nettype wire

[rtl/core/sfce_back.sv]
// Back end: flow-control state, input and output stores, result register.
`default_nettype none

module sfce_back #(
   parameter int IN_DEPTH   = sfce_pkg::IN_DEPTH_DEF,
   parameter int HIGH_WATER = sfce_pkg::HIGH_WATER_DEF,
   parameter int OUT_DEPTH  = sfce_pkg::OUT_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            item_valid,
   input  sfce_pkg::item_type              item,
   output logic                            item_pop,
   input  logic                            csr_wr,
   input  logic [sfce_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sfce_pkg::BYTE_W-1:0]     csr_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_tx_valid,
   output logic [sfce_pkg::BYTE_W-1:0]     rsp_tx_byte,
   output logic                            rsp_rts,
   output logic                            rsp_out_done,
   output logic                            rsp_done_pulse,
   output logic                            rsp_rx_valid,
   output logic [sfce_pkg::BYTE_W-1:0]     rsp_rx_byte,
   output logic [sfce_pkg::CNT_W-1:0]      rsp_rx_count,
   output logic                            rsp_last
);
   import sfce_pkg::*;

   localparam int IN_AW  = $clog2(IN_DEPTH);
   localparam int IN_CW  = $clog2(IN_DEPTH + 1);
   localparam int OUT_AW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
   localparam int OUT_CW = $clog2(OUT_DEPTH + 1);

   localparam logic [IN_CW-1:0]  IN_LIM   = IN_CW'(IN_DEPTH);
   localparam logic [OUT_CW-1:0] OUT_LIM  = OUT_CW'(OUT_DEPTH);
   localparam bit                HW_REACH = (HIGH_WATER <= IN_DEPTH);
   localparam logic [IN_CW-1:0]  HW_VAL   = HW_REACH ? IN_CW'(HIGH_WATER) : '0;

   back_st_type st_ff, st_in;

   logic [BYTE_W-1:0] in_mem  [IN_DEPTH];
   logic [BYTE_W-1:0] out_mem [OUT_DEPTH];

   logic [IN_CW-1:0]  in_fill_ff, in_fill_in;
   logic [OUT_CW-1:0] out_loaded_ff, out_loaded_in;
   logic [OUT_CW-1:0] out_pos_ff, out_pos_in;
   logic              queued_ff, queued_in;
   logic              done_ff, done_in;
   logic              sw_ready_ff, sw_ready_in;
   logic              cts_ff, cts_in;
   logic              tx_idle_ff, tx_idle_in;
   logic              rts_ff, rts_in;
   logic              host_ready_ff, host_ready_in;
   logic [BYTE_W-1:0] xoff_char_ff, xoff_char_in;
   logic              raw_mode_ff, raw_mode_in;

   logic              sent_ff, sent_in;
   logic              pulse_ff, pulse_in;
   logic [IN_CW-1:0]  drain_cnt_ff, drain_cnt_in;
   logic [IN_AW-1:0]  rd_idx_ff, rd_idx_in;
   logic [BYTE_W-1:0] tx_rd_ff;
   logic [BYTE_W-1:0] in_rd_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_tx_valid_ff, rsp_tx_valid_in;
   logic [BYTE_W-1:0] rsp_tx_byte_ff, rsp_tx_byte_in;
   logic              rsp_rts_ff, rsp_rts_in;
   logic              rsp_out_done_ff, rsp_out_done_in;
   logic              rsp_done_pulse_ff, rsp_done_pulse_in;
   logic              rsp_rx_valid_ff, rsp_rx_valid_in;
   logic [BYTE_W-1:0] rsp_rx_byte_ff, rsp_rx_byte_in;
   logic [CNT_W-1:0]  rsp_rx_count_ff, rsp_rx_count_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              exec;
   logic              trig;
   logic              complete_now;
   logic              go_drain;
   logic              in_we, out_we;
   logic [OUT_AW-1:0] tx_addr;
   logic [OUT_CW-1:0] pos_inc;
   logic [IN_CW-1:0]  fill_inc;
   logic [IN_CW-1:0]  idx_inc;
   logic              drain_last;
   logic              slot_free;
   logic              in_rd_en;
   logic [IN_AW-1:0]  in_rd_addr;

   assign exec       = (st_ff == ST_IDLE) && item_valid;
   assign item_pop   = exec;
   assign fill_inc   = in_fill_ff + IN_CW'(1);
   assign idx_inc    = IN_CW'(rd_idx_ff) + IN_CW'(1);
   assign drain_last = (idx_inc == drain_cnt_ff);
   assign slot_free  = !rsp_valid_ff || !rsp_stall;

   // configuration
   always_comb begin
      xoff_char_in = xoff_char_ff;
      raw_mode_in  = raw_mode_ff;
      if (csr_wr && csr_index == REG_XOFF_CHAR) begin
         xoff_char_in = csr_data;
      end
      if (csr_wr && csr_index == REG_RAW_MODE) begin
         raw_mode_in = csr_data[0];
      end
   end

   // request execution
   always_comb begin
      in_fill_in    = in_fill_ff;
      out_loaded_in = out_loaded_ff;
      out_pos_in    = out_pos_ff;
      queued_in     = queued_ff;
      done_in       = done_ff;
      sw_ready_in   = sw_ready_ff;
      cts_in        = cts_ff;
      tx_idle_in    = tx_idle_ff;
      rts_in        = rts_ff;
      host_ready_in = host_ready_ff;
      sent_in       = sent_ff;
      pulse_in      = pulse_ff;
      drain_cnt_in  = drain_cnt_ff;
      trig          = 1'b0;
      complete_now  = 1'b0;
      go_drain      = 1'b0;
      in_we         = 1'b0;
      out_we        = 1'b0;
      tx_addr       = OUT_AW'(out_pos_ff);
      pos_inc       = '0;
      if (exec) begin
         sent_in  = 1'b0;
         pulse_in = 1'b0;
         unique case (item.op)
            OP_RX: begin
               if (!raw_mode_ff) begin
                  if (item.data == xoff_char_ff) begin
                     sw_ready_in = 1'b0;
                  end else if (!sw_ready_ff) begin
                     sw_ready_in = 1'b1;
                     trig        = 1'b1;
                  end
               end
               if (in_fill_ff < IN_LIM) begin
                  in_we      = 1'b1;
                  in_fill_in = fill_inc;
                  if (HW_REACH && fill_inc == HW_VAL) begin
                     rts_in = 1'b0;
                  end
               end
            end
            OP_CTS: begin
               if (!item.level) begin
                  cts_in = 1'b0;
               end else if (!cts_ff) begin
                  cts_in = 1'b1;
                  trig   = 1'b1;
               end
            end
            OP_TXE: begin
               tx_idle_in = 1'b1;
               trig       = 1'b1;
            end
            OP_QUEUE: begin
               if (out_loaded_ff < OUT_LIM) begin
                  out_we        = 1'b1;
                  out_loaded_in = out_loaded_ff + OUT_CW'(1);
               end
            end
            OP_START: begin
               out_pos_in = '0;
               queued_in  = 1'b1;
               if (out_loaded_ff == '0) begin
                  complete_now = 1'b1;
               end else begin
                  trig = 1'b1;
               end
            end
            OP_READ: begin
               if (in_fill_ff != '0) begin
                  go_drain     = 1'b1;
                  in_fill_in   = '0;
                  drain_cnt_in = in_fill_ff;
                  if (!rts_ff && host_ready_ff) begin
                     rts_in = 1'b1;
                  end
               end
            end
            OP_HSTOP: begin
               host_ready_in = 1'b0;
               rts_in        = 1'b0;
            end
            OP_HSTART: begin
               host_ready_in = 1'b1;
               if (!HW_REACH || in_fill_ff < HW_VAL) begin
                  rts_in = 1'b1;
               end
            end
            OP_INHIBIT: begin
               sw_ready_in = !item.level;
            end
            OP_CANCEL: begin
               done_in       = 1'b0;
               queued_in     = 1'b0;
               out_loaded_in = '0;
               out_pos_in    = '0;
            end
            default: begin
            end
         endcase
         // one send attempt per request
         if (trig && cts_in && queued_in && sw_ready_in && tx_idle_in) begin
            if (out_pos_in >= out_loaded_in || out_pos_in >= OUT_LIM) begin
               complete_now = 1'b1;
            end else begin
               sent_in    = 1'b1;
               tx_addr    = OUT_AW'(out_pos_in);
               pos_inc    = out_pos_in + OUT_CW'(1);
               out_pos_in = pos_inc;
               tx_idle_in = 1'b0;
               if (pos_inc >= out_loaded_in) begin
                  complete_now = 1'b1;
               end
            end
         end
         if (complete_now) begin
            done_in       = 1'b1;
            queued_in     = 1'b0;
            pulse_in      = 1'b1;
            out_loaded_in = '0;
            out_pos_in    = '0;
         end
      end
   end

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (item_valid) begin
               st_in = go_drain ? ST_DRAIN : ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               st_in = ST_IDLE;
            end
         end
         ST_DRAIN: begin
            if (slot_free && drain_last) begin
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // result register and store walk
   always_comb begin
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_tx_valid_in   = rsp_tx_valid_ff;
      rsp_tx_byte_in    = rsp_tx_byte_ff;
      rsp_rts_in        = rsp_rts_ff;
      rsp_out_done_in   = rsp_out_done_ff;
      rsp_done_pulse_in = rsp_done_pulse_ff;
      rsp_rx_valid_in   = rsp_rx_valid_ff;
      rsp_rx_byte_in    = rsp_rx_byte_ff;
      rsp_rx_count_in   = rsp_rx_count_ff;
      rsp_last_in       = rsp_last_ff;
      rd_idx_in         = rd_idx_ff;
      in_rd_en          = 1'b0;
      in_rd_addr        = '0;
      unique case (st_ff)
         ST_IDLE: begin
            rd_idx_in = '0;
            in_rd_en  = 1'b1;
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in      = 1'b1;
               rsp_tx_valid_in   = sent_ff;
               rsp_tx_byte_in    = sent_ff ? tx_rd_ff : '0;
               rsp_rts_in        = rts_ff;
               rsp_out_done_in   = done_ff;
               rsp_done_pulse_in = pulse_ff;
               rsp_rx_valid_in   = 1'b0;
               rsp_rx_byte_in    = '0;
               rsp_rx_count_in   = '0;
               rsp_last_in       = 1'b1;
            end
         end
         ST_DRAIN: begin
            if (slot_free) begin
               rsp_valid_in      = 1'b1;
               rsp_tx_valid_in   = 1'b0;
               rsp_tx_byte_in    = '0;
               rsp_rts_in        = rts_ff;
               rsp_out_done_in   = done_ff;
               rsp_done_pulse_in = 1'b0;
               rsp_rx_valid_in   = 1'b1;
               rsp_rx_byte_in    = in_rd_ff;
               rsp_rx_count_in   = CNT_W'(drain_cnt_ff);
               rsp_last_in       = drain_last;
               rd_idx_in         = IN_AW'(idx_inc);
               in_rd_en          = 1'b1;
               in_rd_addr        = IN_AW'(idx_inc);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= ST_IDLE;
         in_fill_ff    <= '0;
         out_loaded_ff <= '0;
         out_pos_ff    <= '0;
         queued_ff     <= 1'b0;
         done_ff       <= 1'b0;
         sw_ready_ff   <= 1'b1;
         cts_ff        <= 1'b0;
         tx_idle_ff    <= 1'b1;
         rts_ff        <= 1'b1;
         host_ready_ff <= 1'b1;
         xoff_char_ff  <= '0;
         raw_mode_ff   <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         st_ff         <= st_in;
         in_fill_ff    <= in_fill_in;
         out_loaded_ff <= out_loaded_in;
         out_pos_ff    <= out_pos_in;
         queued_ff     <= queued_in;
         done_ff       <= done_in;
         sw_ready_ff   <= sw_ready_in;
         cts_ff        <= cts_in;
         tx_idle_ff    <= tx_idle_in;
         rts_ff        <= rts_in;
         host_ready_ff <= host_ready_in;
         xoff_char_ff  <= xoff_char_in;
         raw_mode_ff   <= raw_mode_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sent_ff           <= sent_in;
      pulse_ff          <= pulse_in;
      drain_cnt_ff      <= drain_cnt_in;
      rd_idx_ff         <= rd_idx_in;
      rsp_tx_valid_ff   <= rsp_tx_valid_in;
      rsp_tx_byte_ff    <= rsp_tx_byte_in;
      rsp_rts_ff        <= rsp_rts_in;
      rsp_out_done_ff   <= rsp_out_done_in;
      rsp_done_pulse_ff <= rsp_done_pulse_in;
      rsp_rx_valid_ff   <= rsp_rx_valid_in;
      rsp_rx_byte_ff    <= rsp_rx_byte_in;
      rsp_rx_count_ff   <= rsp_rx_count_in;
      rsp_last_ff       <= rsp_last_in;
   end

   // stores
   always_ff @(posedge clock) begin
      if (in_we) begin
         in_mem[IN_AW'(in_fill_ff)] <= item.data;
      end
      if (in_rd_en) begin
         in_rd_ff <= in_mem[in_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (out_we) begin
         out_mem[OUT_AW'(out_loaded_ff)] <= item.data;
      end
      if (st_ff == ST_IDLE) begin
         tx_rd_ff <= out_mem[tx_addr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tx_valid   = rsp_tx_valid_ff;
   assign rsp_tx_byte    = rsp_tx_byte_ff;
   assign rsp_rts        = rsp_rts_ff;
   assign rsp_out_done   = rsp_out_done_ff;
   assign rsp_done_pulse = rsp_done_pulse_ff;
   assign rsp_rx_valid   = rsp_rx_valid_ff;
   assign rsp_rx_byte    = rsp_rx_byte_ff;
   assign rsp_rx_count   = rsp_rx_count_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

[rtl/core/serial_flow_control_engine_core.sv]
// Serial flow control engine top level: request queue, engine and result register.
// A request passes the request queue and the engine's execute and emit passes before its
// first result is registered; the engine takes no new request until that is done, and a
// stalled result holds it; a read yields one result per stored byte, one store read each.
// Reset: synchronous, active high; stores are not cleared, no clearing pass.
`default_nettype none

module serial_flow_control_engine_core #(
   parameter int IN_DEPTH   = sfce_pkg::IN_DEPTH_DEF,
   parameter int HIGH_WATER = sfce_pkg::HIGH_WATER_DEF,
   parameter int OUT_DEPTH  = sfce_pkg::OUT_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [sfce_pkg::CMD_W-1:0]      req_cmd,
   input  logic [sfce_pkg::BYTE_W-1:0]     req_data,
   input  logic                            req_level,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_tx_valid,
   output logic [sfce_pkg::BYTE_W-1:0]     rsp_tx_byte,
   output logic                            rsp_rts,
   output logic                            rsp_out_done,
   output logic                            rsp_done_pulse,
   output logic                            rsp_rx_valid,
   output logic [sfce_pkg::BYTE_W-1:0]     rsp_rx_byte,
   output logic [sfce_pkg::CNT_W-1:0]      rsp_rx_count,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sfce_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sfce_pkg::BYTE_W-1:0]     csr_data
);
   import sfce_pkg::*;

   logic     item_valid;
   item_type item;
   logic     item_pop;
   logic     csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   sfce_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_cmd    (req_cmd),
      .req_data   (req_data),
      .req_level  (req_level),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   sfce_back #(
      .IN_DEPTH   (IN_DEPTH),
      .HIGH_WATER (HIGH_WATER),
      .OUT_DEPTH  (OUT_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (item_valid),
      .item           (item),
      .item_pop       (item_pop),
      .csr_wr         (csr_wr),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tx_valid   (rsp_tx_valid),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_rts        (rsp_rts),
      .rsp_out_done   (rsp_out_done),
      .rsp_done_pulse (rsp_done_pulse),
      .rsp_rx_valid   (rsp_rx_valid),
      .rsp_rx_byte    (rsp_rx_byte),
      .rsp_rx_count   (rsp_rx_count),
      .rsp_last       (rsp_last)
   );

   // a read never sends
   a_read_no_send: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rx_valid |-> !rsp_tx_valid && !rsp_done_pulse)
      else $error("read result carries a send");

   // completion always leaves done set
   a_pulse_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_pulse |-> rsp_out_done)
      else $error("done pulse without done flag");

   // non-read results are single and carry no drain count
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_rx_valid |-> rsp_last && rsp_rx_count == '0 && rsp_rx_byte == '0)
      else $error("status result malformed");

   // a drained byte comes with a non-zero count
   a_drain_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rx_valid |-> rsp_rx_count != '0 || IN_DEPTH == 64)
      else $error("drained byte with zero count");

endmodule

`default_nettype wire
